[rtl/core/rta_pkg.sv]
// Shared types and constants for the region threshold adapter.
package rta_pkg;

	localparam int DIV_W = 28;
	localparam int DVS_W = 12;
	localparam int MACC_W = 20;
	localparam logic [15:0] RESET_FLOOR = 16'd1280;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		REG_TARGET = 3'd0,
		REG_TOL    = 3'd1,
		REG_MAXCHG = 3'd2,
		REG_FLOOR  = 3'd3,
		REG_CEIL   = 3'd4,
		REG_NREG   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [11:0] target;
		logic [7:0]  tol;
		logic [7:0]  maxchg;
		logic [15:0] floor_v;
		logic [15:0] ceil_v;
		logic [4:0]  nreg;
	} rta_cfg_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  region;
		logic [11:0] keypoint_count;
	} rta_in_t;

	typedef struct packed {
		logic [3:0]  out_region;
		logic [15:0] threshold_value;
		logic [15:0] mean_threshold;
		logic        is_last;
		logic [1:0]  status;
	} rta_out_t;

endpackage

[rtl/core/rta_if.sv]
// Channel interfaces: report input, result output, configuration writes.
interface rta_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [3:0]  region;
	logic [11:0] keypoint_count;
	modport source (output valid, kind, region, keypoint_count, input ready);
	modport sink (input valid, kind, region, keypoint_count, output ready);
endinterface

interface rta_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  out_region;
	logic [15:0] threshold_value;
	logic [15:0] mean_threshold;
	logic        is_last;
	logic [1:0]  status;
	modport source (output valid, out_region, threshold_value, mean_threshold, is_last, status,
		input ready);
	modport sink (input valid, out_region, threshold_value, mean_threshold, is_last, status,
		output ready);
endinterface

interface rta_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/rta_div.sv]
// Restoring serial divider, one quotient bit per cycle.
module rta_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [rta_pkg::DIV_W-1:0] dnd,
	input  logic [rta_pkg::DVS_W-1:0] dvs,
	output logic                      done,
	output logic [rta_pkg::DIV_W-1:0] quot
);
	import rta_pkg::*;

	localparam int CW = $clog2(DIV_W);

	logic             busy_q, done_q;
	logic [CW-1:0]    cnt_q;
	logic [DVS_W-1:0] rem_q, dvs_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W:0]   trial, sub;
	logic             ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge = trial >= {1'b0, dvs_q};
	assign sub = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dnd;
			dvs_q <= dvs;
		end else if (busy_q) begin
			rem_q <= ge ? sub[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule

[rtl/core/rta_engine.sv]
// Threshold and accumulator memories with the read-modify-write sequencer.
module rta_engine #(
	parameter int MAX_REGIONS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rta_pkg::rta_cfg_t cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  rta_pkg::rta_in_t  in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output rta_pkg::rta_out_t out_item
);
	import rta_pkg::*;

	localparam int AW = MAX_REGIONS > 1 ? $clog2(MAX_REGIONS) : 1;
	localparam int NCAP = MAX_REGIONS < 16 ? MAX_REGIONS : 16;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_RA, S_RB, S_RC, S_RW, S_RF,
		S_ARD, S_ADIV, S_AW, S_MW, S_ERD, S_EOUT, S_EMIT
	} state_t;

	state_t state_q, ret_q;

	logic [15:0] thr_mem [MAX_REGIONS];
	logic [23:0] sum_mem [MAX_REGIONS];
	logic [MAX_REGIONS-1:0] thr_vld_q, sum_vld_q;
	logic [AW-1:0] addr_q;
	logic [15:0] thr_rd_q;
	logic [23:0] sum_rd_q;
	logic thr_rv_q, sum_rv_q;

	logic [3:0] reg_q, r_q;
	logic [11:0] kc_q, diff_q, tgt_q;
	logic [15:0] t_q, mean_q;
	logic [23:0] s_q;
	logic up_q, inband_q, capped_q, out_valid_q;
	logic [27:0] mul_q, step_q;
	logic [7:0] cnt_q;
	logic [MACC_W-1:0] macc_q;
	logic [1:0] st_q;
	rta_out_t pend_q, out_q;

	logic div_go_q, div_done;
	logic [DIV_W-1:0] dnd_q, quot;
	logic [DVS_W-1:0] dvs_q;

	logic [4:0] n;
	logic [15:0] thr_eff, p, a;
	logic [23:0] sum_eff, sum_new;
	logic [24:0] sum_wide;
	logic [11:0] tgt, diff, mop;
	logic kge, last;
	logic [19:0] tolp, mcfp;
	logic [27:0] mul_c, step;
	logic [28:0] upsum;
	logic [MACC_W-1:0] macc_nx;
	logic sum_we, thr_we;

	always_comb begin
		if (cfg.nreg == 5'd0) n = 5'd1;
		else if (cfg.nreg > 5'(NCAP)) n = 5'(NCAP);
		else n = cfg.nreg;
	end

	assign thr_eff = thr_rv_q ? thr_rd_q : RESET_FLOOR;
	assign sum_eff = sum_rv_q ? sum_rd_q : 24'd0;
	assign tgt = (cfg.target == 12'd0) ? 12'd1 : cfg.target;
	assign kge = kc_q >= tgt;
	assign diff = kge ? kc_q - tgt : tgt - kc_q;
	assign tolp = {12'd0, cfg.tol} * {8'd0, tgt};
	assign mcfp = {12'd0, cfg.maxchg} * {8'd0, tgt};
	assign mop = capped_q ? {4'd0, cfg.maxchg} : diff_q;
	assign mul_c = {12'd0, t_q} * {16'd0, mop};
	assign step = (step_q < 28'd256) ? 28'd256 : step_q;
	assign upsum = {13'd0, t_q} + {1'b0, step};

	always_comb begin
		if (inband_q) p = t_q;
		else if (!up_q) begin
			if (step >= {12'd0, t_q} || (t_q - step[15:0]) < cfg.floor_v) p = cfg.floor_v;
			else p = t_q - step[15:0];
		end else begin
			if (upsum > {13'd0, cfg.ceil_v}) p = cfg.ceil_v;
			else p = upsum[15:0];
		end
	end

	assign sum_wide = {1'b0, s_q} + {9'd0, p};
	assign sum_new = sum_wide[24] ? 24'hFFFFFF : sum_wide[23:0];
	assign a = (quot > 28'hFFFF) ? 16'hFFFF : quot[15:0];
	assign macc_nx = macc_q + MACC_W'(a);
	assign last = ({1'b0, r_q} == n - 5'd1);
	assign sum_we = (state_q == S_RF);
	assign thr_we = (state_q == S_AW) && div_done;

	always_ff @(posedge clk) begin
		if (sum_we) sum_mem[addr_q] <= sum_new;
		if (thr_we) thr_mem[addr_q] <= a;
		thr_rd_q <= thr_mem[addr_q];
		sum_rd_q <= sum_mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_rv_q <= 1'b0;
			sum_rv_q <= 1'b0;
		end else begin
			thr_rv_q <= thr_vld_q[addr_q];
			sum_rv_q <= sum_vld_q[addr_q];
		end
	end

	rta_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go_q),
		.dnd    (dnd_q),
		.dvs    (dvs_q),
		.done   (div_done),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			thr_vld_q <= '0;
			sum_vld_q <= '0;
			cnt_q <= '0;
			mean_q <= RESET_FLOOR;
			out_valid_q <= 1'b0;
			div_go_q <= 1'b0;
			addr_q <= '0;
			r_q <= '0;
		end else begin
			div_go_q <= 1'b0;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						reg_q <= in_item.region;
						kc_q <= in_item.keypoint_count;
						addr_q <= AW'(in_item.region);
						r_q <= '0;
						macc_q <= '0;
						if (!in_item.kind) begin
							if ({1'b0, in_item.region} >= n) begin
								pend_q <= '{in_item.region, 16'd0, 16'd0, 1'b1, STAT_RANGE};
								ret_q <= S_IDLE;
								state_q <= S_EMIT;
							end else begin
								state_q <= S_RD;
							end
						end else begin
							addr_q <= '0;
							if (cnt_q == 8'd0) begin
								st_q <= STAT_EMPTY;
								for (int i = 0; i < MAX_REGIONS; i++) begin
									if (i < int'(n)) sum_vld_q[i] <= 1'b0;
								end
								state_q <= S_ERD;
							end else begin
								state_q <= S_ARD;
							end
						end
					end
				end
				S_RD: state_q <= S_RA;
				S_RA: begin
					t_q <= thr_eff;
					s_q <= sum_eff;
					diff_q <= diff;
					up_q <= kge;
					tgt_q <= tgt;
					inband_q <= {diff, 8'd0} <= tolp;
					capped_q <= {diff, 8'd0} >= mcfp;
					state_q <= S_RB;
				end
				S_RB: begin
					mul_q <= mul_c;
					state_q <= S_RC;
				end
				S_RC: begin
					if (inband_q) begin
						state_q <= S_RF;
					end else if (capped_q) begin
						step_q <= {8'd0, mul_q[27:8]};
						state_q <= S_RF;
					end else begin
						div_go_q <= 1'b1;
						dnd_q <= mul_q;
						dvs_q <= tgt_q;
						state_q <= S_RW;
					end
				end
				S_RW: begin
					if (div_done) begin
						step_q <= quot;
						state_q <= S_RF;
					end
				end
				S_RF: begin
					sum_vld_q[addr_q] <= 1'b1;
					if ({1'b0, reg_q} == n - 5'd1 && cnt_q != 8'hFF) cnt_q <= cnt_q + 8'd1;
					pend_q <= '{reg_q, p, 16'd0, 1'b1, STAT_OK};
					ret_q <= S_IDLE;
					state_q <= S_EMIT;
				end
				S_ARD: state_q <= S_ADIV;
				S_ADIV: begin
					div_go_q <= 1'b1;
					dnd_q <= DIV_W'(sum_eff);
					dvs_q <= DVS_W'(cnt_q);
					state_q <= S_AW;
				end
				S_AW: begin
					if (div_done) begin
						thr_vld_q[addr_q] <= 1'b1;
						sum_vld_q[addr_q] <= 1'b0;
						macc_q <= macc_nx;
						if (last) begin
							div_go_q <= 1'b1;
							dnd_q <= DIV_W'(macc_nx);
							dvs_q <= DVS_W'(n);
							state_q <= S_MW;
						end else begin
							r_q <= r_q + 4'd1;
							addr_q <= addr_q + 1'b1;
							state_q <= S_ARD;
						end
					end
				end
				S_MW: begin
					if (div_done) begin
						mean_q <= quot[15:0];
						cnt_q <= '0;
						st_q <= STAT_OK;
						r_q <= '0;
						addr_q <= '0;
						state_q <= S_ERD;
					end
				end
				S_ERD: state_q <= S_EOUT;
				S_EOUT: begin
					pend_q <= '{r_q, thr_eff, last ? mean_q : 16'd0, last, st_q};
					if (last) begin
						ret_q <= S_IDLE;
					end else begin
						ret_q <= S_ERD;
						r_q <= r_q + 4'd1;
						addr_q <= addr_q + 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q <= pend_q;
						state_q <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item = out_q;
endmodule

[rtl/core/region_threshold_adapter_unit.sv]
// Region threshold adapter top level: configuration registers and channel ports.
// Report: the input transfer goes through the read, compute and proposal states to the
// result register, and through the serial divide when the step needs it. Apply: an
// averaging divide per region in use, one divide for the mean, then one result per region.
// One item is in work at a time; the result register lets the next item enter.
// Reset: registers take their defaults, thresholds read as 5.0, sums and count zero.
module region_threshold_adapter_unit #(
	parameter int MAX_REGIONS = 16
) (
	input logic    clk,
	input logic    arst_n,
	rta_in_if.sink   item,
	rta_out_if.source result,
	rta_cfg_if.sink  cfg
);
	import rta_pkg::*;

	rta_cfg_t cfg_q;
	rta_in_t  in_item;
	rta_out_t out_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{12'd25, 8'd26, 8'd26, RESET_FLOOR, 16'd25600, 5'd16};
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_TARGET: cfg_q.target <= cfg.data[11:0];
				REG_TOL:    cfg_q.tol <= cfg.data[7:0];
				REG_MAXCHG: cfg_q.maxchg <= cfg.data[7:0];
				REG_FLOOR:  cfg_q.floor_v <= cfg.data;
				REG_CEIL:   cfg_q.ceil_v <= cfg.data;
				REG_NREG:   cfg_q.nreg <= cfg.data[4:0];
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;
	assign in_item = '{item.kind, item.region, item.keypoint_count};

	rta_engine #(.MAX_REGIONS(MAX_REGIONS)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.in_item   (in_item),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_item  (out_item)
	);

	assign result.out_region = out_item.out_region;
	assign result.threshold_value = out_item.threshold_value;
	assign result.mean_threshold = out_item.mean_threshold;
	assign result.is_last = out_item.is_last;
	assign result.status = out_item.status;
endmodule

[sim/region_threshold_adapter_unit_tb.sv]
// Testbench for the region threshold adapter: random and directed reports and applies, scoreboard check.
module region_threshold_adapter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rta_pkg::*;

	class threshold_scoreboard;
		logic [11:0] target;
		logic [7:0]  tol;
		logic [7:0]  maxchg;
		logic [15:0] floor_v;
		logic [15:0] ceil_v;
		logic [4:0]  nreg;
		logic [15:0] applied [16];
		logic [23:0] sums [16];
		logic [7:0]  passes;
		logic [15:0] mean_v;
		rta_out_t    pending [$];
		int          errors;

		function new();
			target = 25;
			tol = 26;
			maxchg = 26;
			floor_v = 16'd1280;
			ceil_v = 16'd25600;
			nreg = 16;
			for (int i = 0; i < 16; i++) begin
				applied[i] = 16'd1280;
				sums[i] = 0;
			end
			passes = 0;
			mean_v = 16'd1280;
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [15:0] v);
			case (idx)
				REG_TARGET: target = v[11:0];
				REG_TOL:    tol = v[7:0];
				REG_MAXCHG: maxchg = v[7:0];
				REG_FLOOR:  floor_v = v;
				REG_CEIL:   ceil_v = v;
				REG_NREG:   nreg = v[4:0];
				default: ;
			endcase
		endfunction

		function int live_regions();
			int n;
			n = nreg;
			if (n == 0) n = 1;
			if (n > 16) n = 16;
			return n;
		endfunction

		function longint proposal(longint t, longint k);
			longint tg, diff, step;
			bit capped;
			tg = (target == 0) ? 1 : target;
			diff = (k < tg) ? tg - k : k - tg;
			if (diff * 256 <= tol * tg) return t;
			capped = diff * 256 >= maxchg * tg;
			step = capped ? (t * maxchg) >> 8 : (t * diff) / tg;
			if (step < 256) step = 256;
			if (k < tg) begin
				if (step >= t || t - step < floor_v) return floor_v;
				return t - step;
			end
			t = t + step;
			if (t > ceil_v) t = ceil_v;
			return t;
		endfunction

		function void note_item(rta_in_t it);
			int n;
			longint p, acc, a;
			rta_out_t o;
			n = live_regions();
			if (it.kind == 1'b0) begin
				o = '0;
				o.out_region = it.region;
				o.is_last = 1'b1;
				if (it.region >= n) begin
					o.status = STAT_RANGE;
				end else begin
					p = proposal(applied[it.region], it.keypoint_count);
					acc = sums[it.region] + p;
					sums[it.region] = (acc > 24'hFFFFFF) ? 24'hFFFFFF : acc[23:0];
					if (it.region == n - 1 && passes < 255) passes++;
					o.threshold_value = p[15:0];
					o.status = STAT_OK;
				end
				pending.push_back(o);
				return;
			end
			if (passes != 0) begin
				acc = 0;
				for (int r = 0; r < n; r++) begin
					a = sums[r] / passes;
					if (a > 16'hFFFF) a = 16'hFFFF;
					applied[r] = a[15:0];
					acc += a;
				end
				mean_v = 16'(acc / n);
			end
			for (int r = 0; r < n; r++) begin
				sums[r] = 0;
				o.out_region = 4'(r);
				o.threshold_value = applied[r];
				o.mean_threshold = (r == n - 1) ? mean_v : 16'd0;
				o.is_last = (r == n - 1);
				o.status = (passes == 0) ? STAT_EMPTY : STAT_OK;
				pending.push_back(o);
			end
			passes = 0;
		endfunction

		function void check_result(rta_out_t got);
			rta_out_t want;
			if (pending.size() == 0) begin
				$display("%0t unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.out_region != want.out_region) begin
				$display("%0t out_region exp %0d got %0d", $time, want.out_region, got.out_region);
				errors++;
			end
			if (got.threshold_value != want.threshold_value) begin
				$display("%0t threshold_value exp %0d got %0d", $time,
					want.threshold_value, got.threshold_value);
				errors++;
			end
			if (got.mean_threshold != want.mean_threshold) begin
				$display("%0t mean_threshold exp %0d got %0d", $time,
					want.mean_threshold, got.mean_threshold);
				errors++;
			end
			if (got.is_last != want.is_last) begin
				$display("%0t is_last exp %0d got %0d", $time, want.is_last, got.is_last);
				errors++;
			end
			if (got.status != want.status) begin
				$display("%0t status exp %0d got %0d", $time, want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   send_idle = 0;
	int   recv_idle = 0;
	longint cycles = 0;
	threshold_scoreboard sb = new();

	rta_in_if  item ();
	rta_out_if result ();
	rta_cfg_if cfg ();

	region_threshold_adapter_unit dut (
		.clk(clk), .arst_n(arst_n), .item(item.sink), .result(result.source), .cfg(cfg.sink)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		item.valid = 1'b0;
		item.kind = 1'b0;
		item.region = '0;
		item.keypoint_count = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		result.ready = 1'b0;
	end

	always @(posedge clk) begin
		rta_out_t got;
		cycles++;
		if (arst_n && result.valid && result.ready) begin
			got.out_region = result.out_region;
			got.threshold_value = result.threshold_value;
			got.mean_threshold = result.mean_threshold;
			got.is_last = result.is_last;
			got.status = result.status;
			sb.check_result(got);
		end
		if (cycles > 3000000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk)
		result.ready <= arst_n && ($urandom_range(99) >= recv_idle);

	task automatic send_item(logic kind, logic [3:0] region, logic [11:0] count);
		rta_in_t it;
		while ($urandom_range(99) < send_idle) @(negedge clk);
		item.valid <= 1'b1;
		item.kind <= kind;
		item.region <= region;
		item.keypoint_count <= count;
		@(posedge clk);
		while (!item.ready) @(posedge clk);
		it.kind = kind;
		it.region = region;
		it.keypoint_count = count;
		sb.note_item(it);
		@(negedge clk);
		item.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] v);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (600) @(negedge clk);
	endtask

	task automatic full_pass(int n);
		for (int r = 0; r < n; r++)
			send_item(1'b0, 4'(r), $urandom_range(0, 3) == 0 ? 12'($urandom_range(4095)) :
				12'($urandom_range(2 * sb.target + 8)));
	endtask

	task automatic random_phase(int count);
		int n;
		n = sb.live_regions();
		while (count > 0) begin
			case ($urandom_range(9))
				0: begin
					send_item(1'b1, 4'($urandom_range(15)), 12'($urandom_range(4095)));
					count -= 1;
				end
				1: begin
					send_item(1'b0, 4'($urandom_range(15)), 12'($urandom_range(4095)));
					count -= 1;
				end
				default: begin
					full_pass(n);
					count -= n;
					if ($urandom_range(2) == 0) begin
						send_item(1'b1, 4'd0, 12'd0);
						count -= 1;
					end
				end
			endcase
		end
		send_item(1'b1, 4'd0, 12'd0);
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(1'b1, 4'd0, 12'd0);
		send_item(1'b0, 4'd0, 12'd0);
		send_item(1'b0, 4'd1, 12'd4095);
		send_item(1'b0, 4'd2, 12'd25);
		send_item(1'b0, 4'd3, 12'd27);
		send_item(1'b0, 4'd4, 12'd20);
		send_item(1'b0, 4'd15, 12'd4095);
		send_item(1'b1, 4'd15, 12'hFFF);
		drain();
		write_reg(REG_NREG, 16'd4);
		write_reg(REG_TARGET, 16'd0);
		write_reg(REG_TOL, 16'd0);
		write_reg(REG_MAXCHG, 16'd255);
		write_reg(REG_FLOOR, 16'd0);
		write_reg(REG_CEIL, 16'hFFFF);
		send_item(1'b0, 4'd9, 12'd1);
		for (int p = 0; p < 3; p++) begin
			send_item(1'b0, 4'd0, 12'd4095);
			send_item(1'b0, 4'd1, 12'd0);
			send_item(1'b0, 4'd2, 12'd1);
			send_item(1'b0, 4'd3, 12'd4095);
		end
		send_item(1'b1, 4'd0, 12'd0);
		drain();

		send_idle = 32;
		recv_idle = 75;
		write_reg(REG_TARGET, 16'd4095);
		write_reg(REG_FLOOR, 16'd40000);
		write_reg(REG_CEIL, 16'd1000);
		write_reg(REG_NREG, 16'd0);
		random_phase(20);
		drain();
		write_reg(REG_TARGET, 16'd30);
		write_reg(REG_TOL, 16'd255);
		write_reg(REG_MAXCHG, 16'd0);
		write_reg(REG_FLOOR, 16'd256);
		write_reg(REG_CEIL, 16'd60000);
		write_reg(REG_NREG, 16'd31);
		random_phase(60);
		drain();

		send_idle = 75;
		recv_idle = 32;
		write_reg(REG_TARGET, 16'd12);
		write_reg(REG_TOL, 16'd10);
		write_reg(REG_MAXCHG, 16'd80);
		write_reg(REG_NREG, 16'd3);
		random_phase(70);
		drain();

		send_idle = 0;
		recv_idle = 0;
		write_reg(REG_TARGET, 16'd1);
		write_reg(REG_TOL, 16'd26);
		write_reg(REG_MAXCHG, 16'd200);
		write_reg(REG_FLOOR, 16'd1280);
		write_reg(REG_CEIL, 16'd25600);
		write_reg(REG_NREG, 16'd7);
		random_phase(60);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

[region_threshold_adapter_unit.f]
rtl/core/rta_pkg.sv
rtl/core/rta_if.sv
rtl/core/rta_div.sv
rtl/core/rta_engine.sv
rtl/core/region_threshold_adapter_unit.sv
sim/region_threshold_adapter_unit_tb.sv
